// File: rtl/core/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;

  // Round constants, one per compression round.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial hash value loaded at reset and after every digest.
  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Source of the byte shifted into the block register.
  typedef enum logic [1:0] {
    SEL_IN   = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_byte;
    byte_sel_e byte_sel;
    logic      init_vars;
    logic      round_en;
    logic      hash_upd;
    logic      hash_init;
    logic      out_next;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [6:0] fill;
    logic       round_last;
    logic       idx_last;
  } sts_t;

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/core/sha_datapath.sv
// Datapath: block and schedule shift register, round unit, hash and length registers.
`timescale 1ns / 1ps
module sha_datapath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  byte_i,
  output sts_t        sts_o,
  output logic [31:0] out_word_o,
  output logic [2:0]  out_idx_o
);

  logic [511:0] blk_q, blk_d;
  logic [31:0]  vars_q [8];
  logic [31:0]  hash_q [8];
  logic [6:0]   fill_q;
  logic [63:0]  len_q;
  logic [5:0]   rnd_q;
  logic [2:0]   idx_q;
  logic [7:0]   byte_mux;
  logic [31:0]  w0, w1, w9, w14, wnew, t1, t2, ch, maj;

  // Byte source for message, padding mark, zero fill and big-endian length.
  always_comb begin
    unique case (cmd_i.byte_sel)
      SEL_IN:   byte_mux = byte_i;
      SEL_MARK: byte_mux = PAD_MARK;
      SEL_ZERO: byte_mux = 8'h00;
      SEL_LEN:  byte_mux = len_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];
      default:  byte_mux = 8'h00;
    endcase
  end

  // Window taps: word 0 sits in the top bits.
  assign w0   = blk_q[511:480];
  assign w1   = blk_q[479:448];
  assign w9   = blk_q[223:192];
  assign w14  = blk_q[63:32];
  assign wnew = ssig1(w14) + w9 + ssig0(w1) + w0;

  // Round function.
  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + bsig1(vars_q[4]) + ch + ROUND_K[rnd_q] + w0;
  assign t2  = bsig0(vars_q[0]) + maj;

  // Bytes shift in one at a time; each round shifts one schedule word.
  always_comb begin
    blk_d = blk_q;
    if (cmd_i.load_byte) begin
      blk_d = {blk_q[503:0], byte_mux};
    end else if (cmd_i.round_en) begin
      blk_d = {blk_q[479:0], wnew};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_vars) begin
      for (int j = 0; j < 8; j++) vars_q[j] <= hash_q[j];
    end else if (cmd_i.round_en) begin
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
    end
  end

  // Chaining hash, fill count, bit length, round and output counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 8; j++) hash_q[j] <= INIT_HASH[j];
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.hash_init) begin
        for (int j = 0; j < 8; j++) hash_q[j] <= INIT_HASH[j];
        len_q <= '0;
      end else if (cmd_i.hash_upd) begin
        for (int j = 0; j < 8; j++) hash_q[j] <= hash_q[j] + vars_q[j];
      end else if (cmd_i.load_byte && cmd_i.byte_sel == SEL_IN) begin
        len_q <= len_q + 64'd8;
      end
      if (cmd_i.hash_upd) begin
        fill_q <= '0;
      end else if (cmd_i.load_byte) begin
        fill_q <= fill_q + 7'd1;
      end
      if (cmd_i.init_vars) begin
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.out_next) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.round_last = (rnd_q == 6'd63);
  assign sts_o.idx_last   = (idx_q == 3'd7);
  assign out_word_o       = hash_q[idx_q];
  assign out_idx_o        = idx_q;

endmodule

// File: rtl/core/sha_ctrl.sv
// Controller: sequences byte intake, padding, compression and digest output.
`timescale 1ns / 1ps
module sha_ctrl import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_has_byte_i,
  input  logic in_end_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_INIT = 6'b000100,
    ST_COMP = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pad_q, pad_d;     // padding of the current message is under way
  logic   mark_q, mark_d;   // the 0x80 mark has been placed
  logic   lenok_q, lenok_d; // the current block takes the length field

  always_comb begin
    state_d     = state_q;
    pad_d       = pad_q;
    mark_d      = mark_q;
    lenok_d     = lenok_q;
    cmd_o       = '0;
    cmd_o.byte_sel = SEL_IN;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = in_has_byte_i;
          if (in_end_i) begin
            pad_d   = 1'b1;
            mark_d  = 1'b0;
            lenok_d = 1'b0;
          end
          if (in_has_byte_i && sts_i.fill == 7'd63) begin
            state_d = ST_INIT;
          end else if (in_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.load_byte = 1'b1;
        if (!mark_q) begin
          cmd_o.byte_sel = SEL_MARK;
          mark_d  = 1'b1;
          lenok_d = (sts_i.fill < 7'd56);
        end else if (sts_i.fill < 7'd56 || !lenok_q) begin
          cmd_o.byte_sel = SEL_ZERO;
        end else begin
          cmd_o.byte_sel = SEL_LEN;
        end
        if (sts_i.fill == 7'd63) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init_vars = 1'b1;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.hash_upd = 1'b1;
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (lenok_q) begin
          state_d = ST_OUT;
        end else begin
          lenok_d = 1'b1;
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.hash_init = 1'b1;
            pad_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenok_q <= lenok_d;
    end
  end

endmodule

// File: rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
// Usage:
// The input stream carries one request per message byte: tdata holds the byte,
// tuser says whether tdata carries a byte, and tlast ends the message (with or
// without a byte of its own). A request with neither flag changes nothing.
// Bytes are taken back to back while tready is high. The 64th byte of a block
// starts a compression (load, rounds on one shared round unit, hash update),
// during which tready is low. At the end of a message the padding bytes (up to
// 64, or up to 72 when the length field needs a second block) enter one a cycle,
// apart from the compression between the two padded blocks; each padded block is
// compressed likewise, then the eight digest words leave on the output stream,
// one per accepted request, word index in tdata, tlast on the eighth.
// While the digest is waiting the input takes no requests; a stalled receiver
// simply holds the current word. After the last word the initial hash and
// length are reloaded for the next message; the hash update clears the fill count.
// Reset clears the hash to its initial value and the block to empty; no
// clearing pass is needed, so the block is ready right after reset.
`timescale 1ns / 1ps
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // has_byte
  input  logic        s_axis_tlast,  // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word [31:0], word_index [34:32], zeros
  output logic        m_axis_tlast   // last_word
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] out_word;
  logic [2:0]  out_idx;

  sha_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_has_byte_i (s_axis_tuser),
    .in_end_i      (s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  sha_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .byte_i     (s_axis_tdata),
    .sts_o      (sts),
    .out_word_o (out_word),
    .out_idx_o  (out_idx)
  );

  assign m_axis_tdata = {5'b00000, out_idx, out_word};
  assign m_axis_tlast = sts.idx_last;

endmodule

// File: rtl/core/sha_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // The block never takes input while a digest word is pending.
  a_no_intake_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while digest pending");

  // The marked word is the eighth digest word.
  a_last_is_index7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == 3'd7)
    else $error("last word with wrong index");

  // A word that is taken and not last is followed by the next index.
  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("digest words out of sequence");

  // A stalled output word holds.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb_sha256_stream_hasher.sv
// Testbench of the SHA-256 stream hasher: byte streams checked against a local digest model.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;
  import sha_pkg::*;

  // Expected digest word with its position.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Local copy of the hasher state.
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  digest_word_t expected_words [$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  bit           idle_enable = 1'b1;

  localparam int unsigned WATCHDOG_LIMIT = 5000;

  sha256_stream_hasher u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // One 64-round compression of msg_block into hash_state.
  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic reset_digest_model();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
    block_fill = 0;
    msg_bits = '0;
  endtask

  // Advance the model by one request and queue any digest words it causes.
  task automatic predict_digest(input logic [7:0] data, input logic has_byte,
                                input logic eom);
    digest_word_t next_w;
    if (has_byte) begin
      msg_block[block_fill] = data;
      msg_bits += 64'd8;
      block_fill++;
      if (block_fill == 64) begin
        compress_msg_block();
        block_fill = 0;
      end
    end
    if (eom) begin
      msg_block[block_fill++] = PAD_MARK;
      if (block_fill > 56) begin
        while (block_fill < 64) msg_block[block_fill++] = 8'h00;
        compress_msg_block();
        block_fill = 0;
      end
      while (block_fill < 56) msg_block[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        next_w.word  = hash_state[i];
        next_w.index = 3'(i);
        next_w.last  = (i == 7);
        expected_words.insert(expected_words.size(), next_w);
      end
      reset_digest_model();
    end
  endtask

  // Send one request and wait for its acceptance.
  task automatic send_request(input logic [7:0] data, input logic has_byte,
                              input logic eom);
    while (idle_enable && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_digest(data, has_byte, eom);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_request(8'($urandom), 1'b1, 1'b0);
    end
    send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop sending and wait until every expected digest word has arrived.
  task automatic wait_digests_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  // Empty message, lone end item and idle items.
  task automatic test_empty_and_idle();
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  // Byte on the end item, extreme byte values and the padding boundaries.
  task automatic test_directed_lengths();
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h80, 1'b1, 1'b1);
    send_request(8'h7f, 1'b1, 1'b1);
    wait_digests_drained();
    send_message(55);
    send_message(56);
  endtask

  // Random messages: mostly short, a few crossing block boundaries, with idle noise.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    int unsigned iter;
    sent = 0;
    iter = 0;
    while (sent < 90) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(20);
      // A stretch of messages with no idling on either side.
      idle_enable = !(iter >= 2 && iter < 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
        send_request(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1));
      end
      if (len == 0 || $urandom_range(1)) send_request(8'($urandom), 1'b0, 1'b1);
      sent += len + 1;
      iter++;
      if ($urandom_range(5) == 0) wait_digests_drained();
    end
    idle_enable = 1'b1;
    // Close any open message.
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  // Receiver side with random stalls.
  always @(negedge clk_i) begin
    m_axis_tready <= !rst_ni ? 1'b0 : !(idle_enable && $urandom_range(99) < 8);
  end

  // Check every accepted digest word against the oldest expectation.
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest word %h", m_axis_tdata[31:0]);
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (m_axis_tdata[31:0] !== exp_w.word) begin
            $error("digest_word: expected %h, got %h", exp_w.word, m_axis_tdata[31:0]);
            error_count++;
          end
          if (m_axis_tdata[34:32] !== exp_w.index) begin
            $error("word_index: expected %0d, got %0d", exp_w.index, m_axis_tdata[34:32]);
            error_count++;
          end
          if (m_axis_tlast !== exp_w.last) begin
            $error("last_word: expected %0d, got %0d", exp_w.last, m_axis_tlast);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request.
  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    reset_digest_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_idle();
    test_directed_lengths();
    test_random_messages();
    wait_digests_drained();
    repeat (200) @(negedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
